### rtl/mae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mae_pkg
// Shared types and constants of the misaligned access emulator.
// ----------------------------------------------------------------------------
package mae_pkg;

    typedef enum logic [1:0] {
        CMD_WR_INT  = 2'd0,
        CMD_WR_FLT  = 2'd1,
        CMD_TRAP    = 2'd2,
        CMD_RD_BYTE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DECLINE = 2'd0,
        KIND_RD_REQ  = 2'd1,
        KIND_WR_REQ  = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    localparam int unsigned CFG_COUNT = 7;
    localparam logic [2:0] CFG_APP_BASE   = 3'd0;
    localparam logic [2:0] CFG_APP_END    = 3'd1;
    localparam logic [2:0] CFG_DRAM_BASE  = 3'd2;
    localparam logic [2:0] CFG_DRAM_ALIAS = 3'd3;
    localparam logic [2:0] CFG_DRAM_SIZE  = 3'd4;
    localparam logic [2:0] CFG_CRAM_BASE  = 3'd5;
    localparam logic [2:0] CFG_CRAM_SIZE  = 3'd6;

    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_FLW   = 7'h07;
    localparam logic [6:0] OPC_FSW   = 7'h27;

    // queued operation from front to back
    typedef struct packed {
        t_kind       kind;      // decline, read (load), write (store), or done-only
        logic        is_load;
        logic [31:0] addr;
        logic [31:0] data;
        logic [2:0]  len;
        logic [31:0] npc;
        logic [4:0]  dest;
        logic        is_float;
        logic        sign_ext;
        logic        writes;
        logic        byte_ret;  // marks a returned byte for a pending load
        logic [7:0]  rbyte;
    } t_op;

endpackage
`default_nettype wire

### rtl/mae_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mae_front
// Register files, decode, address and window check; hands operations to queue.
// ----------------------------------------------------------------------------
module mae_front import mae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [4:0]  i_reg_index,
    input  wire logic [31:0] i_reg_value,
    input  wire logic [31:0] i_trap_cause,
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_fault_pc,
    input  wire logic [7:0]  i_returned_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_op              o_q_op,
    input  wire logic        i_wb_en,
    input  wire logic        i_wb_float,
    input  wire logic [4:0]  i_wb_idx,
    input  wire logic [31:0] i_wb_val
);

    logic [31:0] r_cfg [CFG_COUNT];
    logic [31:0] r_xreg [32];
    logic [31:0] r_freg [32];
    logic        r_pending;
    logic        r_drain;
    logic [2:0]  r_fwant;
    logic [2:0]  r_fgot;
    logic        r_fwr;

    logic        acc;
    logic        ok;
    logic        dec_ok;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] base_reg;
    logic [31:0] imm;
    logic [2:0]  len;
    logic [2:0]  step;
    logic [4:0]  dest;
    logic        is_load, is_float, sign_ext, writes;
    logic [31:0] a_end;
    logic        win;
    logic [15:0] c;
    logic [2:0]  f3;
    logic [2:0]  cf3;
    logic [31:0] imm_i, imm_s;

    // hold input after the completing byte until the load's done is issued
    assign o_ready = !i_q_full && !r_drain;
    assign acc = i_valid && o_ready;
    assign c = i_instruction[15:0];
    assign f3 = i_instruction[14:12];
    assign cf3 = c[15:13];
    assign imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_s = {{20{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};

    always_comb begin
        dec_ok = 1'b0; base_reg = '0; imm = '0; len = 3'd4; step = 3'd4; dest = '0;
        is_load = 1'b0; is_float = 1'b0; sign_ext = 1'b0; writes = 1'b0; data = '0;
        if (i_instruction[1:0] != 2'b11) begin
            step = 3'd2;
            if (c[1:0] == 2'b00 && cf3 inside {3'd2, 3'd3, 3'd6, 3'd7}) begin
                dec_ok = 1'b1;
                base_reg = r_xreg[{2'b01, c[9:7]}];
                imm = {25'd0, c[5], c[12:10], c[6], 2'b00};
                is_float = cf3[0];
                is_load = !cf3[2];
                dest = {2'b01, c[4:2]};
                writes = is_load;
                data = is_float ? r_freg[{2'b01, c[4:2]}] : r_xreg[{2'b01, c[4:2]}];
            end else if (c[1:0] == 2'b10 && cf3 inside {3'd2, 3'd3}) begin
                dec_ok = 1'b1;
                base_reg = r_xreg[2];
                imm = {24'd0, c[3:2], c[12], c[6:4], 2'b00};
                is_load = 1'b1;
                is_float = cf3[0];
                dest = c[11:7];
                writes = cf3[0] || (c[11:7] != 5'd0);
            end else if (c[1:0] == 2'b10 && cf3 inside {3'd6, 3'd7}) begin
                dec_ok = 1'b1;
                base_reg = r_xreg[2];
                imm = {24'd0, c[8:7], c[12:9], 2'b00};
                is_float = cf3[0];
                data = is_float ? r_freg[c[6:2]] : r_xreg[c[6:2]];
            end
        end else begin
            base_reg = r_xreg[i_instruction[19:15]];
            dest = i_instruction[11:7];
            case (i_instruction[6:0])
                OPC_LOAD: begin
                    dec_ok = !(f3 inside {3'd3, 3'd6, 3'd7});
                    len = (f3[1:0] == 2'd2) ? 3'd4 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd1;
                    sign_ext = !f3[2];
                    imm = imm_i;
                    is_load = 1'b1;
                    writes = dest != 5'd0;
                end
                OPC_STORE: begin
                    dec_ok = f3 <= 3'd2;
                    len = (f3 == 3'd2) ? 3'd4 : (f3 == 3'd1) ? 3'd2 : 3'd1;
                    imm = imm_s;
                    data = r_xreg[i_instruction[24:20]];
                    dest = '0;
                end
                OPC_FLW: begin
                    dec_ok = f3 == 3'd2;
                    imm = imm_i;
                    is_load = 1'b1;
                    is_float = 1'b1;
                    writes = 1'b1;
                end
                OPC_FSW: begin
                    dec_ok = f3 == 3'd2;
                    imm = imm_s;
                    is_float = 1'b1;
                    data = r_freg[i_instruction[24:20]];
                    dest = '0;
                end
                default: dec_ok = 1'b0;
            endcase
        end
        if (!is_load) dest = '0;
    end

    assign addr = base_reg + imm;
    assign a_end = addr + {29'd0, len} - 32'd1;

    always_comb begin
        logic [31:0] dl, al, cl;
        dl = r_cfg[CFG_DRAM_BASE] + r_cfg[CFG_DRAM_SIZE];
        al = r_cfg[CFG_DRAM_ALIAS] + r_cfg[CFG_DRAM_SIZE];
        cl = r_cfg[CFG_CRAM_BASE] + r_cfg[CFG_CRAM_SIZE];
        win = (a_end >= addr) && (
              (addr >= r_cfg[CFG_APP_BASE] && a_end < r_cfg[CFG_APP_END]) ||
              (addr >= r_cfg[CFG_DRAM_BASE] && a_end < dl) ||
              (addr >= r_cfg[CFG_CRAM_BASE] && a_end < cl) ||
              (addr >= r_cfg[CFG_DRAM_ALIAS] && a_end < al));
    end

    assign ok = !r_pending && (i_trap_cause == 32'd4 || i_trap_cause == 32'd6)
                && dec_ok && win;

    always_comb begin
        o_q_push = 1'b0;
        o_q_op = '0;
        o_q_op.kind = KIND_DECLINE;
        o_q_op.rbyte = i_returned_byte;
        if (acc && i_command == CMD_TRAP) begin
            o_q_push = 1'b1;
            if (ok) begin
                o_q_op.kind = is_load ? KIND_RD_REQ : KIND_WR_REQ;
                o_q_op.is_load = is_load;
                o_q_op.addr = addr;
                o_q_op.data = data;
                o_q_op.len = len;
                o_q_op.npc = i_fault_pc + {29'd0, step};
                o_q_op.dest = dest;
                o_q_op.is_float = is_float;
                o_q_op.sign_ext = sign_ext;
                o_q_op.writes = writes;
            end
        end else if (acc && i_command == CMD_RD_BYTE && r_pending) begin
            o_q_push = 1'b1;
            o_q_op.byte_ret = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_drain <= 1'b0;
            r_fwant <= '0;
            r_fgot <= '0;
            r_fwr <= 1'b0;
            for (int k = 0; k < CFG_COUNT; k++) r_cfg[k] <= '0;
            for (int k = 0; k < 32; k++) begin
                r_xreg[k] <= '0;
                r_freg[k] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx != 3'd7) r_cfg[i_cfg_idx] <= i_cfg_data;
            if (o_q_push && ok && i_command == CMD_TRAP && is_load) begin
                r_pending <= 1'b1;
                r_fwant <= len;
                r_fgot <= '0;
                r_fwr <= writes;
            end
            if (o_q_push && i_command == CMD_RD_BYTE) begin
                r_fgot <= r_fgot + 3'd1;
                if (r_fgot + 3'd1 >= r_fwant) r_drain <= 1'b1;
            end
            if (i_wb_en) begin
                r_pending <= 1'b0;
                r_drain <= 1'b0;
                if (r_fwr) begin
                    if (i_wb_float) r_freg[i_wb_idx] <= i_wb_val;
                    else if (i_wb_idx != 5'd0) r_xreg[i_wb_idx] <= i_wb_val;
                end
            end
            if (acc && i_command == CMD_WR_INT && i_reg_index != 5'd0)
                r_xreg[i_reg_index] <= i_reg_value;
            if (acc && i_command == CMD_WR_FLT) r_freg[i_reg_index] <= i_reg_value;
        end
    end

endmodule
`default_nettype wire

### rtl/mae_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mae_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module mae_queue import mae_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_op       i_op,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_op       o_op
);

    t_op        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_op = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

### rtl/mae_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mae_back
// Issues byte requests, gathers returned bytes, reports done and writeback.
// ----------------------------------------------------------------------------
module mae_back import mae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_op              i_q_op,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_bus_address,
    output logic [7:0]       o_bus_byte,
    output logic [31:0]      o_next_pc,
    output logic [31:0]      o_load_value,
    output logic [4:0]       o_dest_index,
    output logic             o_dest_is_float,
    output logic             o_dest_written,
    output logic             o_last,
    output logic             o_wb_en,
    output logic             o_wb_float,
    output logic [4:0]       o_wb_idx,
    output logic [31:0]      o_wb_val
);

    logic [2:0]  r_k;
    logic [2:0]  r_got;
    logic [2:0]  r_want;
    logic [31:0] r_gath;
    logic [31:0] r_ppc;
    logic [4:0]  r_pdest;
    logic        r_pf, r_ps, r_pw;

    logic        r_ov;
    logic [1:0]  r_kind;
    logic [31:0] r_addr, r_npc, r_lv;
    logic [7:0]  r_byte;
    logic [4:0]  r_di;
    logic        r_df, r_dw, r_last;

    logic        slot;
    logic        emit;
    logic [31:0] gath_n, v;

    assign slot = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_bus_address = r_addr;
    assign o_bus_byte = r_byte;
    assign o_next_pc = r_npc;
    assign o_load_value = r_lv;
    assign o_dest_index = r_di;
    assign o_dest_is_float = r_df;
    assign o_dest_written = r_dw;
    assign o_last = r_last;

    always_comb begin
        gath_n = r_gath;
        if (r_got < 3'd4) gath_n = r_gath | ({24'd0, i_q_op.rbyte} << {r_got[1:0], 3'b000});
        v = gath_n;
        if (r_ps && r_want == 3'd2) v = {{16{gath_n[15]}}, gath_n[15:0]};
        else if (r_ps && r_want == 3'd1) v = {{24{gath_n[7]}}, gath_n[7:0]};
    end

    // byte returns need no output slot unless they complete the load
    always_comb begin
        o_q_pop = 1'b0; emit = 1'b0; o_wb_en = 1'b0;
        if (i_q_valid) begin
            if (i_q_op.byte_ret) begin
                if (r_got + 3'd1 < r_want) o_q_pop = 1'b1;
                else if (slot) begin
                    o_q_pop = 1'b1; emit = 1'b1; o_wb_en = 1'b1;
                end
            end else if (slot) begin
                emit = 1'b1;
                if (i_q_op.kind == KIND_DECLINE) o_q_pop = 1'b1;
                else if (i_q_op.is_load) o_q_pop = r_k + 3'd1 == i_q_op.len;
                else o_q_pop = r_k == i_q_op.len;
            end
        end
    end

    assign o_wb_float = r_pf;
    assign o_wb_idx = r_pdest;
    assign o_wb_val = v;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= KIND_DECLINE; r_addr <= '0; r_byte <= '0; r_npc <= '0; r_lv <= '0;
            r_di <= '0; r_df <= 1'b0; r_dw <= 1'b0; r_last <= 1'b1;
            if (i_q_op.byte_ret) begin
                r_kind <= KIND_DONE; r_npc <= r_ppc; r_lv <= v; r_di <= r_pdest;
                r_df <= r_pf; r_dw <= r_pw;
            end else if (i_q_op.kind != KIND_DECLINE) begin
                if (!i_q_op.is_load && r_k == i_q_op.len) begin
                    r_kind <= KIND_DONE; r_npc <= i_q_op.npc;
                end else begin
                    r_kind <= i_q_op.kind;
                    r_addr <= i_q_op.addr + {29'd0, r_k};
                    r_byte <= i_q_op.is_load ? 8'd0 : 8'(i_q_op.data >> {r_k[1:0], 3'b000});
                    r_last <= i_q_op.is_load && (r_k + 3'd1 == i_q_op.len);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_k <= '0; r_got <= '0; r_want <= '0; r_gath <= '0;
            r_ppc <= '0; r_pdest <= '0; r_pf <= 1'b0; r_ps <= 1'b0; r_pw <= 1'b0;
        end else begin
            if (emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (i_q_valid && !i_q_op.byte_ret && emit) begin
                r_k <= o_q_pop ? 3'd0 : r_k + 3'd1;
                if (i_q_op.is_load && r_k == 3'd0) begin
                    r_want <= i_q_op.len; r_got <= '0; r_gath <= '0;
                    r_ppc <= i_q_op.npc; r_pdest <= i_q_op.dest;
                    r_pf <= i_q_op.is_float; r_ps <= i_q_op.sign_ext;
                    r_pw <= i_q_op.writes;
                end
            end
            if (o_q_pop && i_q_op.byte_ret) begin
                if (emit) begin
                    r_got <= '0; r_gath <= '0; r_want <= '0;
                end else begin
                    r_got <= r_got + 3'd1; r_gath <= gath_n;
                end
            end
        end
    end

    a_pop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid) else $error("pop of empty queue");
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot) else $error("emit without free output slot");
    a_wb_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wb_en |=> (r_ov && r_kind == KIND_DONE && r_last)) else $error("writeback w/o done");

endmodule
`default_nettype wire

### rtl/misaligned_access_emulator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// misaligned_access_emulator_core
// Emulates misaligned RV32 loads and stores with byte requests.
// ----------------------------------------------------------------------------
// A trap yields one output transaction per cycle while the output is not
// stalled: a decline, up to four byte requests, and for stores a done; a
// load's done follows the last returned byte. An input's first result passes
// through the queue and then the output register. The front accepts one
// transaction per cycle while the two-entry queue has room; the back's single
// output register sets the sustained rate of one result per unstalled cycle.
// After the byte that completes a load, input is held until the load's done
// enters the output register and its destination is written; a stall delays it.
module misaligned_access_emulator_core import mae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [4:0]  i_reg_index,
    input  wire logic [31:0] i_reg_value,
    input  wire logic [31:0] i_trap_cause,
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_fault_pc,
    input  wire logic [7:0]  i_returned_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_bus_address,
    output logic [7:0]       o_bus_byte,
    output logic [31:0]      o_next_pc,
    output logic [31:0]      o_load_value,
    output logic [4:0]       o_dest_index,
    output logic             o_dest_is_float,
    output logic             o_dest_written,
    output logic             o_last
);

    logic        q_full, q_push, q_valid, q_pop;
    t_op         q_in, q_out;
    logic        wb_en, wb_float;
    logic [4:0]  wb_idx;
    logic [31:0] wb_val;

    mae_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_reg_index, .i_reg_value,
        .i_trap_cause, .i_instruction, .i_fault_pc, .i_returned_byte,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_q_full(q_full), .o_q_push(q_push), .o_q_op(q_in),
        .i_wb_en(wb_en), .i_wb_float(wb_float), .i_wb_idx(wb_idx), .i_wb_val(wb_val)
    );

    mae_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_op(q_in), .o_full(q_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_op(q_out)
    );

    mae_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_op(q_out), .o_q_pop(q_pop),
        .o_valid, .i_ready, .o_kind, .o_bus_address, .o_bus_byte, .o_next_pc,
        .o_load_value, .o_dest_index, .o_dest_is_float, .o_dest_written, .o_last,
        .o_wb_en(wb_en), .o_wb_float(wb_float), .o_wb_idx(wb_idx), .o_wb_val(wb_val)
    );

endmodule
`default_nettype wire

### tb/misaligned_access_emulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// misaligned_access_emulator_core_tb
// Drives register writes, misaligned traps and returned bytes into the core
// and checks every byte request, done and decline transaction against an
// in-bench model of the decoder, window check and load gather. A directed
// table runs first, then random trap sequences over several window settings.
// ----------------------------------------------------------------------------
module misaligned_access_emulator_core_tb;
    import mae_pkg::*;

    localparam logic [1:0] RVC_Q0 = 2'd0;
    localparam logic [1:0] RVC_Q2 = 2'd2;
    localparam logic [31:0] CAUSE_LOAD  = 32'd4;
    localparam logic [31:0] CAUSE_STORE = 32'd6;

    typedef struct {
        t_cmd        cmd;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [31:0] cause;
        logic [31:0] insn;
        logic [31:0] pc;
        logic [7:0]  rbyte;
    } t_txn;

    typedef struct {
        t_txn t;
        bit   fixed_decline;
    } t_row;

    typedef struct {
        t_kind       kind;
        logic [31:0] addr;
        logic [7:0]  bt;
        logic [31:0] npc;
        logic [31:0] lv;
        logic [4:0]  di;
        logic        df;
        logic        dw;
        logic        last;
    } t_result;

    typedef struct {
        bit          ld;
        bit          fl;
        bit          sx;
        bit          wr;
        logic [2:0]  len;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] step;
        logic [4:0]  dest;
    } t_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = '0;
    logic [4:0]  i_reg_index = '0;
    logic [31:0] i_reg_value = '0;
    logic [31:0] i_trap_cause = '0;
    logic [31:0] i_instruction = '0;
    logic [31:0] i_fault_pc = '0;
    logic [7:0]  i_returned_byte = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_bus_address;
    logic [7:0]  o_bus_byte;
    logic [31:0] o_next_pc;
    logic [31:0] o_load_value;
    logic [4:0]  o_dest_index;
    logic        o_dest_is_float;
    logic        o_dest_written;
    logic        o_last;

    misaligned_access_emulator_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [31:0] win_cfg [CFG_COUNT];
    logic [31:0] xreg [32];
    logic [31:0] freg [32];
    bit          ld_pend;
    logic [2:0]  ld_want;
    logic [2:0]  ld_got;
    logic [31:0] ld_gath;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_flags;
    logic [31:0] ld_pc;

    t_result expected_q[$];
    int      errors = 0;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;

    function automatic bit window_hit(logic [31:0] a, logic [2:0] len);
        logic [31:0] e;
        e = a + len - 1;
        if (e < a) return 0;
        if (a >= win_cfg[CFG_APP_BASE] && e < win_cfg[CFG_APP_END]) return 1;
        if (a >= win_cfg[CFG_DRAM_BASE] &&
            e < win_cfg[CFG_DRAM_BASE] + win_cfg[CFG_DRAM_SIZE]) return 1;
        if (a >= win_cfg[CFG_CRAM_BASE] &&
            e < win_cfg[CFG_CRAM_BASE] + win_cfg[CFG_CRAM_SIZE]) return 1;
        if (a >= win_cfg[CFG_DRAM_ALIAS] &&
            e < win_cfg[CFG_DRAM_ALIAS] + win_cfg[CFG_DRAM_SIZE]) return 1;
        return 0;
    endfunction

    function automatic bit decode_access(logic [31:0] w, output t_access x);
        logic [2:0]  f3;
        logic [4:0]  r2;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        x = '{default: '0};
        x.len = 3'd4;
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        if (w[1:0] != 2'b11) begin
            f3 = w[15:13];
            x.step = 32'd2;
            if (w[1:0] == RVC_Q0 && f3[1]) begin
                r2 = {2'b01, w[4:2]};
                x.addr = xreg[{2'b01, w[9:7]}] + {w[5], w[12:10], w[6], 2'b00};
                x.fl = f3[0];
                x.ld = !f3[2];
                x.dest = r2;
                x.wr = x.ld;
                x.data = x.fl ? freg[r2] : xreg[r2];
                return 1;
            end
            if (w[1:0] == RVC_Q2 && f3[2:1] == 2'b01) begin
                x.addr = xreg[2] + {w[3:2], w[12], w[6:4], 2'b00};
                x.ld = 1;
                x.fl = f3[0];
                x.dest = w[11:7];
                x.wr = x.fl || w[11:7] != 0;
                return 1;
            end
            if (w[1:0] == RVC_Q2 && f3[2:1] == 2'b11) begin
                r2 = w[6:2];
                x.addr = xreg[2] + {w[8:7], w[12:9], 2'b00};
                x.fl = f3[0];
                x.data = x.fl ? freg[r2] : xreg[r2];
                return 1;
            end
            return 0;
        end
        f3 = w[14:12];
        x.step = 32'd4;
        case (w[6:0])
            OPC_LOAD: begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) return 0;
                x.len = f3[1:0] == 2'd2 ? 3'd4 : f3[1:0] == 2'd1 ? 3'd2 : 3'd1;
                x.sx = !f3[2];
                x.addr = xreg[w[19:15]] + imm_i;
                x.ld = 1;
                x.dest = w[11:7];
                x.wr = w[11:7] != 0;
                return 1;
            end
            OPC_STORE: begin
                if (f3 > 3'd2) return 0;
                x.len = f3 == 3'd2 ? 3'd4 : f3 == 3'd1 ? 3'd2 : 3'd1;
                x.addr = xreg[w[19:15]] + imm_s;
                x.data = xreg[w[24:20]];
                return 1;
            end
            OPC_FLW: begin
                if (f3 != 3'd2) return 0;
                x.addr = xreg[w[19:15]] + imm_i;
                x.ld = 1;
                x.fl = 1;
                x.dest = w[11:7];
                x.wr = 1;
                return 1;
            end
            OPC_FSW: begin
                if (f3 != 3'd2) return 0;
                x.addr = xreg[w[19:15]] + imm_s;
                x.fl = 1;
                x.data = freg[w[24:20]];
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic emulate_txn(t_txn t, bit fixed_decline);
        t_access x;
        t_result r;
        t_result res[$];
        logic [31:0] v;
        case (t.cmd)
            CMD_WR_INT: if (t.idx != 0) xreg[t.idx] = t.val;
            CMD_WR_FLT: freg[t.idx] = t.val;
            CMD_RD_BYTE: begin
                if (ld_pend) begin
                    if (ld_got < 4) ld_gath = ld_gath | (32'(t.rbyte) << (8 * ld_got));
                    ld_got = ld_got + 1;
                    if (ld_got >= ld_want) begin
                        v = ld_gath;
                        if (ld_flags[1] && ld_want == 2) v = {{16{v[15]}}, v[15:0]};
                        if (ld_flags[1] && ld_want == 1) v = {{24{v[7]}}, v[7:0]};
                        if (ld_flags[2]) begin
                            if (ld_flags[0]) freg[ld_dest] = v;
                            else if (ld_dest != 0) xreg[ld_dest] = v;
                        end
                        res.push_back('{KIND_DONE, 0, 0, ld_pc, v, ld_dest, ld_flags[0],
                                        ld_flags[2], 1});
                        ld_pend = 0;
                        ld_want = 0;
                        ld_got = 0;
                        ld_gath = 0;
                        ld_dest = 0;
                        ld_flags = 0;
                        ld_pc = 0;
                    end
                end
            end
            default: begin
                if (ld_pend || (t.cause != CAUSE_LOAD && t.cause != CAUSE_STORE) ||
                    !decode_access(t.insn, x) || !window_hit(x.addr, x.len)) begin
                    res.push_back('{KIND_DECLINE, 0, 0, 0, 0, 0, 0, 0, 1});
                end else if (x.ld) begin
                    for (int k = 0; k < x.len; k++)
                        res.push_back('{KIND_RD_REQ, x.addr + k, 0, 0, 0, 0, 0, 0,
                                        k + 1 == x.len});
                    ld_pend = 1;
                    ld_want = x.len;
                    ld_got = 0;
                    ld_gath = 0;
                    ld_dest = x.dest;
                    ld_flags = {x.wr, x.sx, x.fl};
                    ld_pc = t.pc + x.step;
                end else begin
                    for (int k = 0; k < x.len; k++)
                        res.push_back('{KIND_WR_REQ, x.addr + k, x.data >> (8 * k), 0, 0,
                                        0, 0, 0, 0});
                    res.push_back('{KIND_DONE, 0, 0, t.pc + x.step, 0, 0, 0, 0, 1});
                end
            end
        endcase
        if (fixed_decline) begin
            r = '{KIND_DECLINE, 0, 0, 0, 0, 0, 0, 0, 1};
            expected_q.push_back(r);
        end else begin
            foreach (res[i]) expected_q.push_back(res[i]);
        end
    endtask

    task automatic send_txn(t_txn t, bit fixed_decline = 0);
        if (!calm && $urandom_range(99) < 37) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_command = t.cmd;
        i_reg_index = t.idx;
        i_reg_value = t.val;
        i_trap_cause = t.cause;
        i_instruction = t.insn;
        i_fault_pc = t.pc;
        i_returned_byte = t.rbyte;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        emulate_txn(t, fixed_decline);
        @(negedge i_clk);
    endtask

    task automatic write_window(logic [2:0] idx, logic [31:0] data);
        i_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        win_cfg[idx] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_windows(logic [31:0] v0, v1, v2, v3, v4, v5, v6);
        write_window(CFG_APP_BASE, v0);
        write_window(CFG_APP_END, v1);
        write_window(CFG_DRAM_BASE, v2);
        write_window(CFG_DRAM_ALIAS, v3);
        write_window(CFG_DRAM_SIZE, v4);
        write_window(CFG_CRAM_BASE, v5);
        write_window(CFG_CRAM_SIZE, v6);
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(4))
            0: return win_cfg[CFG_APP_BASE] + $urandom_range(0, 64);
            1: return win_cfg[CFG_DRAM_BASE] + $urandom_range(0, 64);
            2: return win_cfg[CFG_DRAM_ALIAS] + $urandom_range(0, 64);
            3: return win_cfg[CFG_CRAM_BASE] + $urandom_range(0, 64);
            default: return $urandom;
        endcase
    endfunction

    // one trap with optional setup writes, the byte returns it needs, and occasional stray commands
    task automatic trap_sequence(inout int n);
        t_txn t;
        logic [31:0] w;
        logic [4:0]  base;
        logic [2:0]  f3;
        int          form;
        form = $urandom_range(0, 9);
        w = $urandom;
        base = 0;
        if ($urandom_range(99) < 10) begin
            t = '{t_cmd'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
            send_txn(t);
            n++;
        end
        if ($urandom_range(99) < 20) begin
            t = '{CMD_WR_FLT, $urandom, $urandom, 0, 0, 0, 0};
            send_txn(t);
            n++;
        end
        if (form <= 3 || form >= 8) begin
            if ($urandom_range(99) < 60) w[31:25] = $urandom_range(1) ? 7'h00 : 7'h7F;
            f3 = $urandom;
            case (form)
                0: w[6:0] = OPC_LOAD;
                1: w[6:0] = OPC_STORE;
                2: begin w[6:0] = OPC_FLW; if ($urandom_range(99) < 80) f3 = 3'd2; end
                3: begin w[6:0] = OPC_FSW; if ($urandom_range(99) < 80) f3 = 3'd2; end
                8: begin
                    w[6:0] = OPC_LOAD;
                    f3 = {1'($urandom_range(1)), 2'($urandom_range(2))};
                end
                default: begin w[6:0] = OPC_STORE; f3 = 3'($urandom_range(2)); end
            endcase
            w[14:12] = f3;
            base = w[19:15];
        end else if (form == 4) begin
            w[1:0] = RVC_Q0;
            w[15:13] = $urandom_range(99) < 85 ? {1'($urandom), 1'b1, 1'($urandom)} : 3'($urandom);
            base = {2'b01, w[9:7]};
        end else if (form == 5 || form == 6) begin
            w[1:0] = RVC_Q2;
            w[15:13] = {form == 6, 1'b1, 1'($urandom)};
            base = 5'd2;
        end
        if (base != 0 && $urandom_range(99) < 70) begin
            t = '{CMD_WR_INT, base, pick_addr(), 0, 0, 0, 0};
            send_txn(t);
            n++;
        end
        t = '{CMD_TRAP, $urandom, $urandom,
              $urandom_range(99) < 90 ? ($urandom_range(1) ? CAUSE_LOAD : CAUSE_STORE)
                                      : 32'($urandom),
              w, $urandom, $urandom};
        send_txn(t);
        n++;
        while (ld_pend) begin
            if ($urandom_range(99) < 10) begin
                t.cause = CAUSE_LOAD;
                send_txn(t);
                n++;
            end
            t = '{CMD_RD_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            send_txn(t);
            n++;
        end
        if ($urandom_range(99) < 10) begin
            t = '{CMD_RD_BYTE, $urandom, $urandom, 0, 0, 0, $urandom};
            send_txn(t);
            n++;
        end
    endtask

    task automatic random_phase(int items);
        int n;
        n = 0;
        while (n < items) trap_sequence(n);
    endtask

    task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, nm, e, a);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = calm || $urandom_range(99) >= 37;
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction, kind %0d addr %h", $realtime,
                         o_kind, o_bus_address);
                errors++;
            end else begin
                e = expected_q.pop_front();
                check_field("kind", e.kind, o_kind);
                check_field("bus_address", e.addr, o_bus_address);
                check_field("bus_byte", e.bt, o_bus_byte);
                check_field("next_pc", e.npc, o_next_pc);
                check_field("load_value", e.lv, o_load_value);
                check_field("dest_index", e.di, o_dest_index);
                check_field("dest_is_float", e.df, o_dest_is_float);
                check_field("dest_written", e.dw, o_dest_written);
                check_field("last", e.last, o_last);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row dir_tab[] = '{
            '{'{CMD_WR_INT, 5'd1, 32'h0000_1001, 0, 0, 0, 0}, 0},
            '{'{CMD_WR_INT, 5'd0, 32'hFFFF_FFFF, 0, 0, 0, 0}, 0},
            '{'{CMD_WR_FLT, 5'd31, 32'hFFFF_FFFF, 0, 0, 0, 0}, 0},
            '{'{CMD_WR_INT, 5'd2, 32'h8000_0FF0, 0, 0, 0, 0}, 0},
            '{'{CMD_WR_INT, 5'd8, 32'h4000_0000, 0, 0, 0, 0}, 0},
            '{'{CMD_TRAP, 0, 0, 32'd5, 32'h0000_A183, 0, 0}, 1},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_A183, 32'hFFFF_FFFE, 0}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h00}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'hFF}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h80}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h7F}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'hAA}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'hFFF0_9003, 32'h0000_0100, 0}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h34}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h80}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_STORE, 32'h7E10_AFA3, 32'h0000_0200, 0}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_STORE, 32'hFFFF_FFFE, 32'hFFFF_FFFC, 0}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_4004, 32'h0000_0300, 0}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h01}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h02}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h03}, 0},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'h84}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_B183, 0, 0}, 1},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_0003, 0, 0}, 1},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_C283, 32'h0000_0400, 0}, 0},
            '{'{CMD_TRAP, 0, 0, CAUSE_LOAD, 32'h0000_C283, 32'h0000_0404, 0}, 1},
            '{'{CMD_RD_BYTE, 0, 0, 0, 0, 0, 8'hFE}, 0}
        };
        foreach (win_cfg[i]) win_cfg[i] = '0;
        foreach (xreg[i]) xreg[i] = '0;
        foreach (freg[i]) freg[i] = '0;
        ld_pend = 0;
        ld_want = 0;
        ld_got = 0;
        ld_gath = 0;
        ld_dest = 0;
        ld_flags = 0;
        ld_pc = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_windows(32'h0000_1000, 32'h0000_2000, 32'h8000_0000, 32'hA000_0000,
                    32'h0000_1000, 32'h4000_0000, 32'h0000_0100);
        foreach (dir_tab[i]) send_txn(dir_tab[i].t, dir_tab[i].fixed_decline);
        hold_req = 1'b1;
        random_phase(120);

        set_windows(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        calm = 1'b1;
        random_phase(60);
        calm = 1'b0;
        random_phase(60);

        set_windows(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFF0,
                    32'hFFFF_FFFF, 32'h7FFF_FFFC, 32'h0000_0004);
        random_phase(120);

        set_windows(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        random_phase(40);

        i_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
